[hdl/first_fit_block_allocator_unit_macros.svh]
// assertion macros for the first-fit allocator
// used by the top level; needs nothing else
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication under reset
`define FFBA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication under reset
`define FFBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

[hdl/ffba_pkg.sv]
// shared constants, codes and types of the first-fit allocator
// no dependencies
`default_nettype none
package ffba_pkg;
    localparam int FREE_ENTRIES = 64;
    localparam int USED_ENTRIES = 64;
    localparam int FADDR_W = $clog2(FREE_ENTRIES);
    localparam int UADDR_W = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;
    localparam int FCNT_W  = $clog2(FREE_ENTRIES + 1);
    localparam int UCNT_W  = $clog2(USED_ENTRIES + 1);
    localparam int IDX_W   = (FCNT_W > UCNT_W) ? FCNT_W : UCNT_W;
    localparam int WORD_W  = 32;
    localparam int ENTRY_W = 2 * WORD_W;

    // operation codes
    localparam logic [1:0] OP_ALLOC    = 2'd0;
    localparam logic [1:0] OP_FREE     = 2'd1;
    localparam logic [1:0] OP_COALESCE = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_FIT   = 3'd1;
    localparam logic [2:0] ST_NOT_FND  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_ZERO_REQ = 3'd4;

    // register indexes
    localparam logic CFG_POOL_BASE  = 1'b0;
    localparam logic CFG_POOL_LIMIT = 1'b1;

    localparam logic [WORD_W-1:0] POOL_LIMIT_RST = 32'd16777216;

    typedef struct packed {
        logic [WORD_W-1:0] start;
        logic [WORD_W-1:0] size;
    } t_entry;
endpackage
`default_nettype wire

[hdl/ffba_req_if.sv]
// request channel of the allocator: valid, ready and the operation payload
// depends on nothing
`default_nettype none
interface ffba_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] request_size;
    logic [31:0] release_start;

    modport source (output valid, operation, request_size, release_start, input ready);
    modport sink   (input valid, operation, request_size, release_start, output ready);
endinterface
`default_nettype wire

[hdl/ffba_rsp_if.sv]
// response channel of the allocator: valid, ready and the result payload
// depends on nothing
`default_nettype none
interface ffba_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] block_offset;
    logic [6:0]  free_blocks;

    modport source (output valid, status, block_offset, free_blocks, input ready);
    modport sink   (input valid, status, block_offset, free_blocks, output ready);
endinterface
`default_nettype wire

[hdl/first_fit_block_allocator_unit.sv]
// first-fit allocator top level: sequencer over the free-list and used-list RAMs
// depends on ffba_pkg, ffba_req_if, ffba_rsp_if, ffba_ram and the macro header
// allocate and free scan their list one entry at a time and then shift the later entries
// down to close the gap; coalesce runs bubble passes over the free list until a pass
// makes no swap, then one merge pass.
// one transaction at a time; each RAM has one read and one write port per cycle.
// reset (synchronous, active low) and any register write rebuild the pool.
`default_nettype none
`include "first_fit_block_allocator_unit_macros.svh"
module first_fit_block_allocator_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    ffba_req_if.sink                        i_req,
    ffba_rsp_if.source                      o_rsp,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [ffba_pkg::WORD_W-1:0] i_cfg_data
);
    import ffba_pkg::*;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE,
        S_A_RD, S_A_CHK, S_A_SR, S_A_SW, S_A_APP,
        S_F_RD, S_F_CHK, S_U_SR, S_U_SW,
        S_S_R0, S_S_L0, S_S_RD, S_S_CMP, S_S_WL,
        S_M_R0, S_M_L0, S_M_RD, S_M_CMP, S_M_WL,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [WORD_W-1:0]   r_base, r_limit;
    logic [FCNT_W-1:0]   r_fcnt;
    logic [UCNT_W-1:0]   r_ucnt;
    logic [IDX_W-1:0]    r_idx;
    logic [FCNT_W-1:0]   r_wr;
    logic                r_swapped;
    logic [WORD_W-1:0]   r_req, r_rel;
    t_entry              r_cur;
    logic [2:0]          r_status;
    logic [WORD_W-1:0]   r_offset;
    logic                r_ov;
    logic [2:0]          r_o_status;
    logic [WORD_W-1:0]   r_o_offset;
    logic [6:0]          r_o_free;

    logic                fram_we, uram_we;
    logic [FADDR_W-1:0]  fram_waddr, fram_raddr;
    logic [UADDR_W-1:0]  uram_waddr, uram_raddr;
    t_entry              fram_wdata, uram_wdata, fq, uq;
    logic [IDX_W-1:0]    idx_nx;
    logic [IDX_W-1:0]    fcnt_x, ucnt_x;
    logic                cur_gt, merge_ok, take_out;
    logic [WORD_W:0]     cur_end, nxt_end;

    assign idx_nx = r_idx + IDX_W'(1);
    assign fcnt_x = IDX_W'(r_fcnt);
    assign ucnt_x = IDX_W'(r_ucnt);

    // sort order and merge test against the entry just read
    assign cur_gt   = (r_cur.start > fq.start) ||
                      ((r_cur.start == fq.start) && (r_cur.size > fq.size));
    assign cur_end  = {1'b0, r_cur.start} + {1'b0, r_cur.size};
    assign nxt_end  = {1'b0, fq.start} + {1'b0, fq.size};
    assign merge_ok = (cur_end == {1'b0, fq.start}) && !nxt_end[WORD_W];

    // memory port control
    always_comb begin
        fram_we    = 1'b0;
        fram_waddr = '0;
        fram_wdata = r_cur;
        fram_raddr = r_idx[FADDR_W-1:0];
        uram_we    = 1'b0;
        uram_waddr = '0;
        uram_wdata = '{start: r_cur.start, size: r_req};
        uram_raddr = r_idx[UADDR_W-1:0];
        case (r_state)
            S_INIT: begin
                fram_we    = 1'b1;
                fram_wdata = '{start: r_base,
                               size: (r_limit >= r_base) ? (r_limit - r_base) : '0};
            end
            S_A_SR, S_S_RD, S_M_RD: fram_raddr = idx_nx[FADDR_W-1:0];
            S_A_SW: begin
                fram_we    = 1'b1;
                fram_waddr = r_idx[FADDR_W-1:0];
                fram_wdata = fq;
            end
            S_A_APP: begin
                fram_we    = 1'b1;
                fram_waddr = FADDR_W'(r_fcnt - FCNT_W'(1));
                fram_wdata = '{start: r_cur.start + r_req, size: r_cur.size - r_req};
                uram_we    = 1'b1;
                uram_waddr = r_ucnt[UADDR_W-1:0];
            end
            S_F_CHK: begin
                fram_we    = (uq.start == r_rel) && (fcnt_x < IDX_W'(FREE_ENTRIES));
                fram_waddr = r_fcnt[FADDR_W-1:0];
                fram_wdata = uq;
            end
            S_U_SR: uram_raddr = idx_nx[UADDR_W-1:0];
            S_U_SW: begin
                uram_we    = 1'b1;
                uram_waddr = r_idx[UADDR_W-1:0];
                uram_wdata = uq;
            end
            S_S_R0, S_M_R0: fram_raddr = '0;
            // second entry of the pass, compared in the first compare step
            S_S_L0, S_M_L0: fram_raddr = FADDR_W'(1);
            S_S_CMP: begin
                fram_we    = 1'b1;
                fram_waddr = FADDR_W'(r_idx - IDX_W'(1));
                fram_wdata = cur_gt ? fq : r_cur;
            end
            S_S_WL: begin
                fram_we    = 1'b1;
                fram_waddr = FADDR_W'(r_fcnt - FCNT_W'(1));
            end
            S_M_CMP: begin
                fram_we    = !merge_ok;
                fram_waddr = r_wr[FADDR_W-1:0];
            end
            S_M_WL: begin
                fram_we    = 1'b1;
                fram_waddr = r_wr[FADDR_W-1:0];
            end
            default: ;
        endcase
    end

    ffba_ram #(.WIDTH(ENTRY_W), .DEPTH(FREE_ENTRIES)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (fram_we),
        .i_waddr (fram_waddr),
        .i_wdata (fram_wdata),
        .i_raddr (fram_raddr),
        .o_rdata (fq)
    );

    ffba_ram #(.WIDTH(ENTRY_W), .DEPTH(USED_ENTRIES)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (uram_we),
        .i_waddr (uram_waddr),
        .i_wdata (uram_wdata),
        .i_raddr (uram_raddr),
        .o_rdata (uq)
    );

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.block_offset = r_o_offset;
    assign o_rsp.free_blocks  = r_o_free;
    assign take_out           = !r_ov || o_rsp.ready;

    // sequencer, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_base  <= '0;
            r_limit <= POOL_LIMIT_RST;
            r_fcnt  <= FCNT_W'(1);
            r_ucnt  <= '0;
            r_ov    <= 1'b0;
        end else begin
            // output valid: set when a result is loaded, cleared when taken
            if ((r_state == S_OUT) && take_out && !i_cfg_we) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                // register write rebuilds the pool
                if (i_cfg_idx == CFG_POOL_BASE) begin
                    r_base <= i_cfg_data;
                end else begin
                    r_limit <= i_cfg_data;
                end
                r_state <= S_INIT;
            end else begin
                case (r_state)
                    S_INIT: begin
                        r_fcnt  <= FCNT_W'(1);
                        r_ucnt  <= '0;
                        r_state <= S_IDLE;
                    end
                    S_IDLE: begin
                        if (i_req.valid) begin
                            r_req    <= i_req.request_size;
                            r_rel    <= i_req.release_start;
                            r_idx    <= '0;
                            r_offset <= '0;
                            case (i_req.operation)
                                OP_ALLOC: begin
                                    if (i_req.request_size == '0) begin
                                        r_status <= ST_ZERO_REQ;
                                        r_state  <= S_OUT;
                                    end else begin
                                        r_status <= ST_OK;
                                        r_state  <= S_A_RD;
                                    end
                                end
                                OP_FREE: begin
                                    if (r_ucnt == '0) begin
                                        r_status <= ST_NOT_FND;
                                        r_state  <= S_OUT;
                                    end else begin
                                        r_status <= ST_OK;
                                        r_state  <= S_F_RD;
                                    end
                                end
                                OP_COALESCE: begin
                                    r_status <= ST_OK;
                                    r_state  <= (r_fcnt > FCNT_W'(1)) ? S_S_R0 : S_OUT;
                                end
                                default: begin
                                    r_status <= ST_OK;
                                    r_state  <= S_OUT;
                                end
                            endcase
                        end
                    end
                    // first-fit scan
                    S_A_RD: r_state <= S_A_CHK;
                    S_A_CHK: begin
                        if (fq.size >= r_req) begin
                            if (ucnt_x >= IDX_W'(USED_ENTRIES)) begin
                                r_status <= ST_FULL;
                                r_state  <= S_OUT;
                            end else begin
                                r_cur   <= fq;
                                r_state <= S_A_SR;
                            end
                        end else if (idx_nx == fcnt_x) begin
                            r_status <= ST_NO_FIT;
                            r_state  <= S_OUT;
                        end else begin
                            r_idx   <= idx_nx;
                            r_state <= S_A_RD;
                        end
                    end
                    // close the gap in the free list
                    S_A_SR: r_state <= (idx_nx < fcnt_x) ? S_A_SW : S_A_APP;
                    S_A_SW: begin
                        r_idx   <= idx_nx;
                        r_state <= S_A_SR;
                    end
                    S_A_APP: begin
                        r_ucnt   <= r_ucnt + UCNT_W'(1);
                        r_offset <= r_cur.start;
                        r_state  <= S_OUT;
                    end
                    // used-list search
                    S_F_RD: r_state <= S_F_CHK;
                    S_F_CHK: begin
                        if (uq.start == r_rel) begin
                            if (fcnt_x >= IDX_W'(FREE_ENTRIES)) begin
                                r_status <= ST_FULL;
                                r_state  <= S_OUT;
                            end else begin
                                r_fcnt  <= r_fcnt + FCNT_W'(1);
                                r_state <= S_U_SR;
                            end
                        end else if (idx_nx == ucnt_x) begin
                            r_status <= ST_NOT_FND;
                            r_state  <= S_OUT;
                        end else begin
                            r_idx   <= idx_nx;
                            r_state <= S_F_RD;
                        end
                    end
                    // close the gap in the used list
                    S_U_SR: begin
                        if (idx_nx < ucnt_x) begin
                            r_state <= S_U_SW;
                        end else begin
                            r_ucnt  <= r_ucnt - UCNT_W'(1);
                            r_state <= S_OUT;
                        end
                    end
                    S_U_SW: begin
                        r_idx   <= idx_nx;
                        r_state <= S_U_SR;
                    end
                    // bubble pass: carry the larger entry forward
                    S_S_R0: r_state <= S_S_L0;
                    S_S_L0: begin
                        r_cur     <= fq;
                        r_idx     <= IDX_W'(1);
                        r_swapped <= 1'b0;
                        r_state   <= S_S_CMP;
                    end
                    S_S_RD: begin
                        r_idx   <= idx_nx;
                        r_state <= S_S_CMP;
                    end
                    S_S_CMP: begin
                        if (cur_gt) begin
                            r_swapped <= 1'b1;
                        end else begin
                            r_cur <= fq;
                        end
                        r_state <= (idx_nx < fcnt_x) ? S_S_RD : S_S_WL;
                    end
                    S_S_WL: r_state <= r_swapped ? S_S_R0 : S_M_R0;
                    // merge pass over the sorted list
                    S_M_R0: r_state <= S_M_L0;
                    S_M_L0: begin
                        r_cur   <= fq;
                        r_idx   <= IDX_W'(1);
                        r_wr    <= '0;
                        r_state <= S_M_CMP;
                    end
                    S_M_RD: begin
                        r_idx   <= idx_nx;
                        r_state <= S_M_CMP;
                    end
                    S_M_CMP: begin
                        if (merge_ok) begin
                            r_cur.size <= r_cur.size + fq.size;
                        end else begin
                            r_cur <= fq;
                            r_wr  <= r_wr + FCNT_W'(1);
                        end
                        r_state <= (idx_nx < fcnt_x) ? S_M_RD : S_M_WL;
                    end
                    S_M_WL: begin
                        r_fcnt  <= r_wr + FCNT_W'(1);
                        r_state <= S_OUT;
                    end
                    // hand the result to the output register
                    S_OUT: begin
                        if (take_out) begin
                            r_o_status <= r_status;
                            r_o_offset <= r_offset;
                            r_o_free   <= 7'(r_fcnt);
                            r_state    <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    `FFBA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n,
        i_req.valid && i_req.ready && !i_cfg_we, r_state != S_IDLE)
    `FFBA_ASSERT_NOW(a_free_list_nonempty, i_clk, i_rst_n, r_state == S_IDLE, r_fcnt != '0)
    `FFBA_ASSERT_NOW(a_counts_bounded, i_clk, i_rst_n, 1'b1,
        (fcnt_x <= IDX_W'(FREE_ENTRIES)) && (ucnt_x <= IDX_W'(USED_ENTRIES)))
endmodule
`default_nettype wire

[hdl/ffba_ram.sv]
// generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none
module ffba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
